// ===== src/m3inv_pkg.sv =====
// Shared constants, types and the cofactor selection table of the 3x3 matrix inverter.
package m3inv_pkg;

  localparam int ELEM_W        = 32;
  localparam int N_ELEM        = 9;
  localparam int N_PROD        = 2 * N_ELEM;
  localparam int THR_W         = 17;
  localparam logic [THR_W-1:0] THR_RESET = 17'd7;
  localparam int FRAC_BITS_DEF = 16;

  localparam int PROD_W = 2 * ELEM_W;
  localparam int COF_W  = PROD_W + 1;
  localparam int MAG_W  = PROD_W;
  localparam int DW     = 96;
  localparam int DETW   = DW + 2;
  localparam int QB     = ELEM_W + 1;
  localparam int WW     = DW + QB - 1;
  localparam int FRONT  = 6;

  typedef logic [N_ELEM-1:0][ELEM_W-1:0] mat_t;

  // Element indexes (row * 3 + column) of the two products of each cofactor.
  localparam int unsigned COF_SEL [N_ELEM][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  typedef struct packed {
    logic                sing;
    logic [ELEM_W-1:0]   det;
    logic [N_ELEM-1:0]   qneg;
    mat_t                elems;
  } side_t;

endpackage

// ===== src/m3inv_in_if.sv =====
// Input channel carrying one 3x3 matrix per word.
interface m3inv_in_if;
  logic valid;
  logic ready;
  logic signed [m3inv_pkg::ELEM_W-1:0] elem_r0c0, elem_r0c1, elem_r0c2;
  logic signed [m3inv_pkg::ELEM_W-1:0] elem_r1c0, elem_r1c1, elem_r1c2;
  logic signed [m3inv_pkg::ELEM_W-1:0] elem_r2c0, elem_r2c1, elem_r2c2;

  modport source(output valid, elem_r0c0, elem_r0c1, elem_r0c2, elem_r1c0, elem_r1c1,
                 elem_r1c2, elem_r2c0, elem_r2c1, elem_r2c2, input ready);
  modport sink(input valid, elem_r0c0, elem_r0c1, elem_r0c2, elem_r1c0, elem_r1c1,
               elem_r1c2, elem_r2c0, elem_r2c1, elem_r2c2, output ready);
endinterface

// ===== src/m3inv_out_if.sv =====
// Result channel carrying the inverse, the determinant and the singular flag.
interface m3inv_out_if;
  logic valid;
  logic ready;
  logic signed [m3inv_pkg::ELEM_W-1:0] res_r0c0, res_r0c1, res_r0c2;
  logic signed [m3inv_pkg::ELEM_W-1:0] res_r1c0, res_r1c1, res_r1c2;
  logic signed [m3inv_pkg::ELEM_W-1:0] res_r2c0, res_r2c1, res_r2c2;
  logic signed [m3inv_pkg::ELEM_W-1:0] determinant;
  logic singular;

  modport source(output valid, res_r0c0, res_r0c1, res_r0c2, res_r1c0, res_r1c1, res_r1c2,
                 res_r2c0, res_r2c1, res_r2c2, determinant, singular, input ready);
  modport sink(input valid, res_r0c0, res_r0c1, res_r0c2, res_r1c0, res_r1c1, res_r1c2,
               res_r2c0, res_r2c1, res_r2c2, determinant, singular, output ready);
endinterface

// ===== src/m3inv_div.sv =====
// Pipelined restoring divider producing one quotient bit per stage.
module m3inv_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [m3inv_pkg::WW-1:0]    num_i,
  input  logic [m3inv_pkg::DW-1:0]    den_i,
  output logic [m3inv_pkg::QB-1:0]    quo_o
);

  localparam int WW = m3inv_pkg::WW;
  localparam int DW = m3inv_pkg::DW;
  localparam int QB = m3inv_pkg::QB;

  logic [WW-1:0] rem_r [QB-1];
  logic [DW-1:0] den_r [QB-1];
  logic [QB-1:0] quo_r [QB];

  for (genvar s = 0; s < QB; s++) begin : g_stage
    logic [WW-1:0] rem_in;
    logic [WW-1:0] sub;
    logic [WW-1:0] rem_nxt;
    logic [DW-1:0] den_in;
    logic [QB-1:0] quo_in;
    logic [QB-1:0] quo_nxt;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign quo_in = quo_r[s-1];
    end

    assign sub     = WW'(den_in) << (QB - 1 - s);
    assign ge      = rem_in >= sub;
    assign rem_nxt = ge ? rem_in - sub : rem_in;
    assign quo_nxt = {quo_in[QB-2:0], ge};

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[s] <= quo_nxt;
      end
    end

    if (s < QB - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= rem_nxt;
          den_r[s] <= den_in;
        end
      end
    end
  end

  assign quo_o = quo_r[QB-1];

endmodule

// ===== src/matrix3x3_inverse_top.sv =====
// Top level of the pipelined 3x3 fixed-point matrix inverter.
//
//   channel   direction  contents
//   in_ch     in         nine Q elements of one matrix, valid/ready
//   out_ch    out        nine results, determinant, singular flag, valid/ready
//   cfg_*     in         singular threshold write, no read-back
//
// A word enters every cycle while the output is taken or empty, and its result leaves
// after six stages of products, cofactors, determinant and divider operands, 33 divider
// stages (one quotient bit each, nine dividers in parallel) and the output register.
// Reset is synchronous and clears every valid bit and sets the threshold to 7.
// When the output word is not taken, the whole pipeline holds.
module matrix3x3_inverse_top #(
  parameter int FRAC_BITS = m3inv_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [m3inv_pkg::THR_W-1:0]    cfg_wdata,
  m3inv_in_if.sink                       in_ch,
  m3inv_out_if.source                    out_ch
);

  localparam int ELEM_W = m3inv_pkg::ELEM_W;
  localparam int N_ELEM = m3inv_pkg::N_ELEM;
  localparam int N_PROD = m3inv_pkg::N_PROD;
  localparam int PROD_W = m3inv_pkg::PROD_W;
  localparam int COF_W  = m3inv_pkg::COF_W;
  localparam int MAG_W  = m3inv_pkg::MAG_W;
  localparam int DW     = m3inv_pkg::DW;
  localparam int DETW   = m3inv_pkg::DETW;
  localparam int QB     = m3inv_pkg::QB;
  localparam int WW     = m3inv_pkg::WW;
  localparam int FRONT  = m3inv_pkg::FRONT;
  localparam int SHIFT2 = 2 * FRAC_BITS;
  localparam int HALF   = ELEM_W;

  function automatic logic [ELEM_W-1:0] sat_mag(input logic [DW-1:0] mag, input logic neg);
    logic [ELEM_W-1:0] r;
    if (neg) begin
      if (mag > DW'({1'b1, {(ELEM_W-1){1'b0}}})) begin
        r = {1'b1, {(ELEM_W-1){1'b0}}};
      end else begin
        r = ELEM_W'(0) - mag[ELEM_W-1:0];
      end
    end else begin
      if (mag > DW'({(ELEM_W-1){1'b1}})) begin
        r = {1'b0, {(ELEM_W-1){1'b1}}};
      end else begin
        r = mag[ELEM_W-1:0];
      end
    end
    return r;
  endfunction

  logic                        en;
  logic [m3inv_pkg::THR_W-1:0] thr_r;
  logic [FRONT-1:0]            fv_r, fv_nxt;
  logic [QB-1:0]               dv_r, dv_nxt;
  logic                        out_v_r;

  m3inv_pkg::mat_t in_mat;
  logic signed [ELEM_W-1:0] in_el [N_ELEM];

  m3inv_pkg::mat_t          mat1_r, mat2_r, mat3_r, mat4_r, mat5_r;
  logic signed [PROD_W-1:0] prod_nxt [N_PROD];
  logic signed [PROD_W-1:0] prod1_r  [N_PROD];
  logic signed [COF_W-1:0]  cof_nxt  [N_ELEM];
  logic signed [COF_W-1:0]  cof2_r   [N_ELEM];
  logic signed [COF_W-1:0]  cof3_r   [N_ELEM];
  logic signed [COF_W-1:0]  cof4_r   [N_ELEM];
  logic signed [COF_W-1:0]  cof5_r   [N_ELEM];
  logic [PROD_W-1:0]        plo_nxt [3], phi_nxt [3], plo3_r [3], phi3_r [3];
  logic [2:0]               tneg_nxt, tneg3_r;
  logic signed [DETW-1:0]   term_nxt [3], term4_r [3];
  logic signed [DETW-1:0]   det5_r;

  logic                     dneg;
  logic signed [DETW-1:0]   dabs;
  logic [DW-1:0]            dmag;
  logic [DW-1:0]            thr_sh;
  logic [WW-1:0]            num_nxt [N_ELEM];
  logic [WW-1:0]            num6_r  [N_ELEM];
  logic [DW-1:0]            dmag6_r;
  m3inv_pkg::side_t         side_nxt, side6_r;
  m3inv_pkg::side_t         side_r [QB];
  logic [QB-1:0]            quo [N_ELEM];

  logic [ELEM_W-1:0]        res_nxt [N_ELEM];
  logic [ELEM_W-1:0]        res_r   [N_ELEM];
  logic [ELEM_W-1:0]        det_out_r;
  logic                     sing_out_r;

  assign en          = !out_v_r || out_ch.ready;
  assign in_ch.ready = en;

  assign in_mat[0] = in_ch.elem_r0c0;
  assign in_mat[1] = in_ch.elem_r0c1;
  assign in_mat[2] = in_ch.elem_r0c2;
  assign in_mat[3] = in_ch.elem_r1c0;
  assign in_mat[4] = in_ch.elem_r1c1;
  assign in_mat[5] = in_ch.elem_r1c2;
  assign in_mat[6] = in_ch.elem_r2c0;
  assign in_mat[7] = in_ch.elem_r2c1;
  assign in_mat[8] = in_ch.elem_r2c2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= m3inv_pkg::THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  assign fv_nxt = {fv_r[FRONT-2:0], in_ch.valid};
  assign dv_nxt = {dv_r[QB-2:0], fv_r[FRONT-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r    <= '0;
      dv_r    <= '0;
      out_v_r <= 1'b0;
    end else if (en) begin
      fv_r    <= fv_nxt;
      dv_r    <= dv_nxt;
      out_v_r <= dv_r[QB-1];
    end
  end

  // Products, cofactors and the determinant.
  always_comb begin
    for (int i = 0; i < N_ELEM; i++) begin
      in_el[i] = in_mat[i];
    end
    for (int c = 0; c < N_ELEM; c++) begin
      prod_nxt[2*c]   = in_el[m3inv_pkg::COF_SEL[c][0]] * in_el[m3inv_pkg::COF_SEL[c][1]];
      prod_nxt[2*c+1] = in_el[m3inv_pkg::COF_SEL[c][2]] * in_el[m3inv_pkg::COF_SEL[c][3]];
      cof_nxt[c]      = COF_W'(prod1_r[2*c]) - COF_W'(prod1_r[2*c+1]);
    end
  end

  always_comb begin
    logic signed [COF_W-1:0]  cm;
    logic signed [ELEM_W-1:0] e;
    logic [ELEM_W-1:0]        em;
    logic [DW-1:0]            tmag;
    for (int k = 0; k < 3; k++) begin
      cm          = cof2_r[3*k][COF_W-1] ? -cof2_r[3*k] : cof2_r[3*k];
      e           = mat2_r[k];
      em          = e[ELEM_W-1] ? ELEM_W'(-e) : e;
      plo_nxt[k]  = PROD_W'(cm[HALF-1:0]) * PROD_W'(em);
      phi_nxt[k]  = PROD_W'(cm[MAG_W-1:HALF]) * PROD_W'(em);
      tneg_nxt[k] = e[ELEM_W-1] ^ cof2_r[3*k][COF_W-1];
      tmag        = DW'({phi3_r[k], {HALF{1'b0}}}) + DW'(plo3_r[k]);
      term_nxt[k] = tneg3_r[k] ? -DETW'(tmag) : DETW'(tmag);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mat1_r  <= in_mat;
      prod1_r <= prod_nxt;
      mat2_r  <= mat1_r;
      cof2_r  <= cof_nxt;
      mat3_r  <= mat2_r;
      cof3_r  <= cof2_r;
      plo3_r  <= plo_nxt;
      phi3_r  <= phi_nxt;
      tneg3_r <= tneg_nxt;
      mat4_r  <= mat3_r;
      cof4_r  <= cof3_r;
      term4_r <= term_nxt;
      mat5_r  <= mat4_r;
      cof5_r  <= cof4_r;
      det5_r  <= term4_r[0] + term4_r[1] + term4_r[2];
    end
  end

  // Magnitude, threshold test and divider operands.
  always_comb begin
    logic signed [COF_W-1:0] cm;
    dneg   = det5_r[DETW-1];
    dabs   = dneg ? -det5_r : det5_r;
    dmag   = dabs[DW-1:0];
    thr_sh = DW'(thr_r) << SHIFT2;
    side_nxt.sing  = (dmag == '0) || (dmag < thr_sh);
    side_nxt.det   = sat_mag(dmag >> SHIFT2, dneg);
    side_nxt.elems = mat5_r;
    for (int c = 0; c < N_ELEM; c++) begin
      cm               = cof5_r[c][COF_W-1] ? -cof5_r[c] : cof5_r[c];
      num_nxt[c]       = WW'(cm[MAG_W-1:0]) << SHIFT2;
      side_nxt.qneg[c] = cof5_r[c][COF_W-1] ^ dneg;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side6_r <= side_nxt;
      dmag6_r <= dmag;
      num6_r  <= num_nxt;
      side_r[0] <= side6_r;
      for (int s = 1; s < QB; s++) begin
        side_r[s] <= side_r[s-1];
      end
    end
  end

  for (genvar c = 0; c < N_ELEM; c++) begin : g_div
    m3inv_div u_div (
      .clk   (clk),
      .en    (en),
      .num_i (num6_r[c]),
      .den_i (dmag6_r),
      .quo_o (quo[c])
    );
  end

  always_comb begin
    for (int c = 0; c < N_ELEM; c++) begin
      res_nxt[c] = side_r[QB-1].sing ? side_r[QB-1].elems[c]
                                     : sat_mag(DW'(quo[c]), side_r[QB-1].qneg[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r      <= res_nxt;
      det_out_r  <= side_r[QB-1].det;
      sing_out_r <= side_r[QB-1].sing;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.res_r0c0    = res_r[0];
  assign out_ch.res_r0c1    = res_r[1];
  assign out_ch.res_r0c2    = res_r[2];
  assign out_ch.res_r1c0    = res_r[3];
  assign out_ch.res_r1c1    = res_r[4];
  assign out_ch.res_r1c2    = res_r[5];
  assign out_ch.res_r2c0    = res_r[6];
  assign out_ch.res_r2c1    = res_r[7];
  assign out_ch.res_r2c2    = res_r[8];
  assign out_ch.determinant = det_out_r;
  assign out_ch.singular    = sing_out_r;

  a_nonsingular_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    fv_r[FRONT-1] && !side6_r.sing |-> dmag6_r != '0)
    else $error("nonsingular word has a zero determinant");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_v_r && fv_r == '0 && dv_r == '0)
    else $error("pipeline holds a word after reset");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable({fv_r, dv_r, out_v_r}))
    else $error("valid bits moved during a stall");

endmodule
